// File: sv/urlpc_pkg.sv
// Shared types, character codes, character-class and hex-conversion
// functions for the URL percent codec. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urlpc_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [3:0] NIB_MASK = 4'hF;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
    held_t           held_next;
    logic [7:0]      digit_next;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return is_digit(c) || is_upper(c) || is_lower(c) || (c == CH_DASH) ||
           (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else begin
      v = 8'h00;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [3:0] m;
    m = nib & NIB_MASK;
    if (m < 4'd10) begin
      return {4'h0, m} + 8'h30;
    end
    return {4'h0, m} + 8'h37;
  endfunction

endpackage

`default_nettype wire

// File: sv/urlpc_step.sv
// Single-pass conversion of one registered input word into up to three
// result bytes and the next held state. Depends on urlpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urlpc_step (
  input  logic              direction,
  input  urlpc_pkg::held_t  held,
  input  logic [7:0]        digit,
  input  logic [7:0]        b,
  input  logic              last,
  output urlpc_pkg::step_t  res
);
  import urlpc_pkg::*;

  logic       fr_hold;
  logic [7:0] fr_byte;

  assign fr_hold = (b == CH_PCT) && !last;
  assign fr_byte = (b == CH_PLUS) ? CH_SPACE : b;

  always_comb begin
    res            = '0;
    res.held_next  = held;
    res.digit_next = digit;
    if (!direction) begin
      if (is_unreserved(b)) begin
        res.bytes[0] = b;
        res.n        = 2'd1;
      end else begin
        res.bytes[0] = CH_PCT;
        res.bytes[1] = hex_char(b[7:4]);
        res.bytes[2] = hex_char(b[3:0]);
        res.n        = 2'd3;
      end
    end else begin
      case (held)
        HELD_PCT: begin
          if (is_hex(b)) begin
            if (last) begin
              res.bytes[0]  = CH_PCT;
              res.bytes[1]  = b;
              res.n         = 2'd2;
              res.held_next = HELD_NONE;
            end else begin
              res.held_next  = HELD_DIGIT;
              res.digit_next = b;
              res.n          = 2'd0;
            end
          end else begin
            res.bytes[0] = CH_PCT;
            if (fr_hold) begin
              res.held_next = HELD_PCT;
              res.n         = 2'd1;
            end else begin
              res.held_next = HELD_NONE;
              res.bytes[1]  = fr_byte;
              res.n         = 2'd2;
            end
          end
        end
        HELD_DIGIT: begin
          res.digit_next = 8'h00;
          res.held_next  = HELD_NONE;
          if (is_hex(b)) begin
            res.bytes[0] = {hex_nibble(digit), hex_nibble(b)};
            res.n        = 2'd1;
          end else begin
            res.bytes[0] = CH_PCT;
            res.bytes[1] = digit;
            if (fr_hold) begin
              res.held_next = HELD_PCT;
              res.n         = 2'd2;
            end else begin
              res.bytes[2] = fr_byte;
              res.n        = 2'd3;
            end
          end
        end
        default: begin
          if (fr_hold) begin
            res.held_next = HELD_PCT;
            res.n         = 2'd0;
          end else begin
            res.held_next = HELD_NONE;
            res.bytes[0]  = fr_byte;
            res.n         = 2'd1;
          end
        end
      endcase
    end
    if (last) begin
      res.held_next  = HELD_NONE;
      res.digit_next = 8'h00;
    end
  end

endmodule

`default_nettype wire

// File: sv/urlpc_outbuf.sv
// Result register: holds up to three result bytes of one input word and
// shifts them out one word per cycle while out_stall is low. Depends on urlpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urlpc_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  urlpc_pkg::step_t res,
  input  logic             last,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             string_end
);
  import urlpc_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      rem;
  logic            fin;
  logic            take;

  assign out_valid  = (rem != 2'd0);
  assign take       = out_valid && !out_stall;
  assign ready      = (rem == 2'd0) || ((rem == 2'd1) && take);
  assign out_byte   = bytes[0];
  assign run_last   = (rem == 2'd1);
  assign string_end = run_last && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= res.n;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      fin   <= last;
    end else if (take) begin
      bytes <= {8'h00, bytes[2], bytes[1]};
    end
  end

endmodule

`default_nettype wire

// File: sv/url_percent_codec.sv
// URL percent codec top level: input register, held-character state,
// conversion logic and result register. Depends on urlpc_pkg, urlpc_step,
// urlpc_outbuf.
// Each input word passes the input register and then the result register.
// Throughput: one input word per cycle while each yields at most one result
// and out_stall is low; an escaped byte in encode mode yields three results.
// Reset clears direction (encode), held characters and the valid state of both registers.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       string_end
);
  import urlpc_pkg::*;

  logic       direction;
  held_t      held_count;
  logic [7:0] held_digit;
  logic       in_full;
  logic [7:0] in_b;
  logic       in_l;
  logic       ready;
  logic       advance;
  logic       accept;
  step_t      res;

  assign advance  = in_full && ready;
  assign in_stall = in_full && !ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_b <= in_byte;
      in_l <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      held_count <= HELD_NONE;
      held_digit <= 8'h00;
    end else if (wr_en) begin
      direction  <= wr_data;
      held_count <= HELD_NONE;
      held_digit <= 8'h00;
    end else if (advance) begin
      held_count <= res.held_next;
      held_digit <= res.digit_next;
    end
  end

  urlpc_step u_step (
    .direction (direction),
    .held      (held_count),
    .digit     (held_digit),
    .b         (in_b),
    .last      (in_l),
    .res       (res)
  );

  urlpc_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .res        (res),
    .last       (in_l),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

`default_nettype wire
